@@ rtl/ordered_value_list_top_macros.svh @@
// ----------------------------------------------------------------------------
// ordered value list assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_TOP_MACROS_SVH
`define ORDERED_VALUE_LIST_TOP_MACROS_SVH

`ifndef SYNTHESIS
// plain property sampled on the block clock, off during reset
`define OVL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition now implies consequence on the next clock
`define OVL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
// condition now implies consequence now
`define OVL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define OVL_ASSERT(lbl, prop, msg)
`define OVL_ASSERT_NEXT(lbl, ante, cons, msg)
`define OVL_ASSERT_NOW(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/ovl_pkg.sv @@
// ----------------------------------------------------------------------------
// ovl_pkg
// shared types and codes of the ordered value list
// ----------------------------------------------------------------------------
package ovl_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 13;
    localparam int CAPACITY_DEF = 16;

    // request codes
    localparam logic [1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [1:0] REQ_INS_BACK  = 2'd1;
    localparam logic [1:0] REQ_DELETE    = 2'd2;
    localparam logic [1:0] REQ_SEARCH    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] item_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] found_position;
    } t_out_word;

endpackage

@@ rtl/ovl_ram.sv @@
// ----------------------------------------------------------------------------
// ovl_ram
// list storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module ovl_ram #(
    parameter int DEPTH = ovl_pkg::CAPACITY_DEF,
    parameter int AW    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [AW-1:0]                      i_wr_addr,
    input  logic signed [ovl_pkg::DATA_W-1:0]  i_wr_data,
    input  logic [AW-1:0]                      i_rd_addr,
    output logic signed [ovl_pkg::DATA_W-1:0]  o_rd_data
);

    logic signed [ovl_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [ovl_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ordered_value_list_top.sv @@
// ----------------------------------------------------------------------------
// ordered_value_list_top
// bounded ordered list of signed values: insert front/back, delete, search
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_stall  | o_out_word (t_out_word)
//
//  one request at a time; the list memory has a single read and a single write
//  port, so walks and shifts move one entry per clock
//  insert back and rejected requests: go from idle straight to the done state
//  search, delete, insert front: walk the list in the scan, down or up state first
//  reset leaves the list empty; storage contents are not cleared
//  a waiting result sits in the output register, the next request is taken
//  meanwhile and only its completion waits for the register to free up
// ----------------------------------------------------------------------------
`include "ordered_value_list_top_macros.svh"

module ordered_value_list_top #(
    parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ovl_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ovl_pkg::t_out_word o_out_word
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW    = ovl_pkg::POS_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request
    localparam logic [2:0] S_SCAN = 3'd1;   // walk from the front comparing
    localparam logic [2:0] S_DOWN = 3'd2;   // close the gap after a delete
    localparam logic [2:0] S_UP   = 3'd3;   // open a slot at the front
    localparam logic [2:0] S_DONE = 3'd4;   // hand result to output register

    logic [2:0]                        r_state, n_state;
    logic [1:0]                        r_op, n_op;
    logic signed [ovl_pkg::DATA_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]                  r_cnt, n_cnt;
    logic [CNT_W-1:0]                  r_rptr, n_rptr;     // next entry to read
    logic                              r_rv, n_rv;         // read data in flight
    logic [IDX_W-1:0]                  r_ridx, n_ridx;     // entry of that data
    ovl_pkg::t_out_word                r_res, n_res;
    logic                              r_ovld, n_ovld;
    ovl_pkg::t_out_word                r_oword, n_oword;

    logic                              ram_we;
    logic [IDX_W-1:0]                  ram_waddr;
    logic signed [ovl_pkg::DATA_W-1:0] ram_wdata;
    logic [IDX_W-1:0]                  ram_raddr;
    logic signed [ovl_pkg::DATA_W-1:0] ram_rdata;

    logic                              full;
    logic                              empty;
    logic                              hit;
    logic [CNT_W-1:0]                  rptr_dec;
    logic                              cnt_step_ok;

    ovl_ram #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign full     = (r_cnt == CNT_W'(CAPACITY));
    assign empty    = (r_cnt == '0);
    // the one shared comparator: returned entry against the request value
    assign hit      = r_rv && (ram_rdata == r_val);
    assign rptr_dec = r_rptr - 1'b1;
    // entry count moves by at most one per clock
    assign cnt_step_ok = (n_cnt == r_cnt) || (n_cnt == r_cnt + 1'b1) || (n_cnt + 1'b1 == r_cnt);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_val     = r_val;
        n_cnt     = r_cnt;
        n_rptr    = r_rptr;
        n_rv      = r_rv;
        n_ridx    = r_ridx;
        n_res     = r_res;
        n_ovld    = r_ovld;
        n_oword   = r_oword;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_val;
        ram_raddr = '0;

        // output word leaves when the consumer takes it
        if (r_ovld && !i_out_stall) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op                 = i_in_word.req_type;
                    n_val                = i_in_word.item_value;
                    n_rv                 = 1'b0;
                    n_res.status         = ovl_pkg::ST_OK;
                    n_res.found_position = '0;
                    case (i_in_word.req_type)
                        ovl_pkg::REQ_INS_FRONT: begin
                            if (full) begin
                                n_res.status = ovl_pkg::ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_rptr  = r_cnt;
                                n_state = S_UP;
                            end
                        end
                        ovl_pkg::REQ_INS_BACK: begin
                            if (full) begin
                                n_res.status = ovl_pkg::ST_FULL;
                            end else begin
                                // append straight away, write port is free here
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[IDX_W-1:0];
                                ram_wdata = i_in_word.item_value;
                                n_cnt     = r_cnt + 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        ovl_pkg::REQ_DELETE, ovl_pkg::REQ_SEARCH: begin
                            if (empty) begin
                                n_res.status = ovl_pkg::ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_rptr  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                n_rv = 1'b0;
                if (r_rptr < r_cnt) begin
                    ram_raddr = r_rptr[IDX_W-1:0];
                    n_rv      = 1'b1;
                    n_ridx    = r_rptr[IDX_W-1:0];
                    n_rptr    = r_rptr + 1'b1;
                end
                if (hit) begin
                    n_rv = 1'b0;
                    if (r_op == ovl_pkg::REQ_SEARCH) begin
                        n_res.found_position = PW'(r_ridx) + 1'b1;
                        n_state              = S_DONE;
                    end else begin
                        // shift later entries down by one, starting after the match
                        n_rptr  = CNT_W'(r_ridx) + 1'b1;
                        n_state = S_DOWN;
                    end
                end else if (!r_rv && (r_rptr == r_cnt)) begin
                    n_res.status = ovl_pkg::ST_NOT_FOUND;
                    n_state      = S_DONE;
                end
            end

            S_DOWN: begin
                n_rv = 1'b0;
                if (r_rv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ridx - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (r_rptr < r_cnt) begin
                    ram_raddr = r_rptr[IDX_W-1:0];
                    n_rv      = 1'b1;
                    n_ridx    = r_rptr[IDX_W-1:0];
                    n_rptr    = r_rptr + 1'b1;
                end else if (!r_rv) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end
            end

            S_UP: begin
                n_rv = 1'b0;
                if (r_rv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ridx + 1'b1;
                    ram_wdata = ram_rdata;
                end
                // walk from the back toward the front
                if (r_rptr != '0) begin
                    ram_raddr = rptr_dec[IDX_W-1:0];
                    n_rv      = 1'b1;
                    n_ridx    = rptr_dec[IDX_W-1:0];
                    n_rptr    = rptr_dec;
                end else if (!r_rv) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = r_val;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_ovld || !i_out_stall) begin
                    n_oword = r_res;
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rv    <= n_rv;
            r_ovld  <= n_ovld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_val   <= n_val;
        r_rptr  <= n_rptr;
        r_ridx  <= n_ridx;
        r_res   <= n_res;
        r_oword <= n_oword;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_word  = r_oword;

    // checks
    `OVL_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(CAPACITY), "entry count above capacity")
    `OVL_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall, "accept left no work")
    `OVL_ASSERT(a_cnt_step, cnt_step_ok, "entry count jumped")
    `OVL_ASSERT_NOW(a_load_from_done, $rose(r_ovld), $past(r_state) == S_DONE, "load outside done")
    `OVL_ASSERT_NOW(a_idle_no_read, !o_in_stall, !r_rv, "read in flight while idle")

endmodule

@@ tb/ordered_value_list_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list_top_tb
// drives insert, delete and search words into the ordered value list, keeps
// its own copy of the list to predict every status and search position, and
// checks each result word in order under random idling on both channels
// ----------------------------------------------------------------------------
module ordered_value_list_top_tb;

    localparam int CAPACITY    = ovl_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 500000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    ovl_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    ovl_pkg::t_out_word out_word;

    // shadow copy of the list, updated when a request word is accepted
    logic [ovl_pkg::DATA_W-1:0] list_vals [CAPACITY];
    int                         list_len = 0;

    ovl_pkg::t_out_word         expected_results [$];
    logic [ovl_pkg::DATA_W-1:0] value_pool [8];
    int                         err_count        = 0;
    int                         cycle_count      = 0;
    int                         rx_freeze_cycles = 0;
    bit                         no_idle          = 1'b0;

    ordered_value_list_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // applies one request to the shadow list and returns the result word
    function automatic ovl_pkg::t_out_word apply_request(input ovl_pkg::t_in_word w);
        ovl_pkg::t_out_word r;
        int                 hit;
        r.status         = ovl_pkg::ST_OK;
        r.found_position = '0;
        hit              = -1;
        case (w.req_type)
            ovl_pkg::REQ_INS_FRONT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ovl_pkg::ST_FULL;
                end else begin
                    for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
                    list_vals[0] = w.item_value;
                    list_len++;
                end
            end
            ovl_pkg::REQ_INS_BACK: begin
                if (list_len >= CAPACITY) begin
                    r.status = ovl_pkg::ST_FULL;
                end else begin
                    list_vals[list_len] = w.item_value;
                    list_len++;
                end
            end
            default: begin
                // delete and search both look for the first equal entry
                if (list_len == 0) begin
                    r.status = ovl_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        if (hit < 0 && list_vals[i] == w.item_value) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = ovl_pkg::ST_NOT_FOUND;
                    end else if (w.req_type == ovl_pkg::REQ_SEARCH) begin
                        r.found_position = ovl_pkg::POS_W'(hit + 1);
                    end else begin
                        for (int i = hit; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
                        list_len--;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // mostly values that can match: live entries and a small pool
    function automatic logic [ovl_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35 && list_len > 0) return list_vals[$urandom_range(0, list_len - 1)];
        if (sel < 80) return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // offers one request word after a random gap and waits for its handshake
    task automatic send_request(input logic [1:0] op, input logic [ovl_pkg::DATA_W-1:0] val);
        ovl_pkg::t_in_word w;
        int                gap;
        w.req_type   = op;
        w.item_value = val;
        gap          = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_results.push_back(apply_request(w));
    endtask

    // sender goes quiet until every expected result word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        // delete and search on the empty list
        send_request(ovl_pkg::REQ_SEARCH, 32'd5);
        send_request(ovl_pkg::REQ_DELETE, 32'd5);
        // fill to capacity with extremes and a duplicate
        send_request(ovl_pkg::REQ_INS_BACK, 32'h8000_0000);
        send_request(ovl_pkg::REQ_INS_FRONT, 32'h7fff_ffff);
        send_request(ovl_pkg::REQ_INS_BACK, 32'h0000_0000);
        send_request(ovl_pkg::REQ_INS_BACK, 32'hffff_ffff);
        send_request(ovl_pkg::REQ_INS_FRONT, 32'd7);
        send_request(ovl_pkg::REQ_INS_BACK, 32'd7);
        for (int i = 0; i < CAPACITY - 6; i++) begin
            send_request(i[0] ? ovl_pkg::REQ_INS_FRONT : ovl_pkg::REQ_INS_BACK,
                         32'h5a5a_0000 + i);
        end
        // both inserts bounce off the full list
        send_request(ovl_pkg::REQ_INS_FRONT, 32'd1);
        send_request(ovl_pkg::REQ_INS_BACK, 32'd1);
        // first match wins, last entry, and a miss
        send_request(ovl_pkg::REQ_SEARCH, 32'd7);
        send_request(ovl_pkg::REQ_SEARCH, list_vals[CAPACITY-1]);
        send_request(ovl_pkg::REQ_SEARCH, 32'd12345);
        // delete only the first duplicate, then a miss
        send_request(ovl_pkg::REQ_DELETE, 32'd7);
        send_request(ovl_pkg::REQ_SEARCH, 32'd7);
        send_request(ovl_pkg::REQ_DELETE, 32'd12345);
        send_request(ovl_pkg::REQ_DELETE, 32'h8000_0000);
        wait_drained();
    endtask

    // random walk that swings between growing to full and shrinking to empty
    task automatic test_random_mix(input int n_items);
        bit growing;
        int r;
        growing = 1'b1;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom();
        for (int n = 0; n < n_items; n++) begin
            if (list_len == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
            if (list_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
            r = $urandom_range(0, 99);
            if (growing) begin
                if (r < 35)      send_request(ovl_pkg::REQ_INS_FRONT, pick_value());
                else if (r < 70) send_request(ovl_pkg::REQ_INS_BACK, pick_value());
                else if (r < 85) send_request(ovl_pkg::REQ_DELETE, pick_value());
                else             send_request(ovl_pkg::REQ_SEARCH, pick_value());
            end else begin
                if (r < 12)      send_request(ovl_pkg::REQ_INS_FRONT, pick_value());
                else if (r < 24) send_request(ovl_pkg::REQ_INS_BACK, pick_value());
                else if (r < 70) send_request(ovl_pkg::REQ_DELETE, pick_value());
                else             send_request(ovl_pkg::REQ_SEARCH, pick_value());
            end
        end
        wait_drained();
    endtask

    // back-to-back words on both channels
    task automatic test_no_idle();
        no_idle = 1'b1;
        test_random_mix(120);
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_output_holdoff();
        rx_freeze_cycles = 300;
        no_idle          = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_request(n[0] ? ovl_pkg::REQ_SEARCH : ovl_pkg::REQ_INS_BACK, pick_value());
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // empty the list by deleting live entries, then poke the empty list
    task automatic test_drain_list();
        while (list_len > 0) begin
            send_request(ovl_pkg::REQ_DELETE, list_vals[$urandom_range(0, list_len - 1)]);
        end
        send_request(ovl_pkg::REQ_SEARCH, 32'h7fff_ffff);
        send_request(ovl_pkg::REQ_DELETE, 32'h8000_0000);
        send_request(ovl_pkg::REQ_INS_FRONT, 32'hffff_ffff);
        send_request(ovl_pkg::REQ_SEARCH, 32'hffff_ffff);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(1250);
        test_no_idle();
        test_output_holdoff();
        test_drain_list();
        // let any stray word show up before the verdict
        repeat (CAPACITY + 8) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // result side: random stall per word, plus a long hold-off on request
    initial begin
        int gap;
        forever begin
            @(posedge clk);
            if (rx_freeze_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (rx_freeze_cycles) @(posedge clk);
                rx_freeze_cycles = 0;
                out_stall <= 1'b0;
            end else if (out_valid && !out_stall) begin
                // a word left at this edge, draw the wait before the next one
                gap = no_idle ? 0 : $urandom_range(0, 10);
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // compare each accepted result word against the oldest expectation
    always @(posedge clk) begin
        ovl_pkg::t_out_word exp_w;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, got status %0d position %0d",
                         $time, out_word.status, out_word.found_position);
                err_count++;
            end else begin
                exp_w = expected_results.pop_front();
                if (out_word.status !== exp_w.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, exp_w.status, out_word.status);
                    err_count++;
                end
                if (out_word.found_position !== exp_w.found_position) begin
                    $display("%0t: position mismatch, expected %0d, got %0d",
                             $time, exp_w.found_position, out_word.found_position);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

@@ ordered_value_list_top.f @@
+incdir+rtl
rtl/ovl_pkg.sv
rtl/ovl_ram.sv
rtl/ordered_value_list_top.sv
tb/ordered_value_list_top_tb.sv
